/* hw/rtl/tfb_pkg.sv */
// tfb_pkg: shared constants, result word type and latency helper for the frame builder
`default_nettype none
package tfb_pkg;

    // unit scale of the frame vectors (one = 2^UNIT_FRAC_BITS)
    localparam int UNIT_FRAC_BITS = 14;

    // configuration register
    localparam int THR_W         = 11;
    localparam int THR_RESET     = 1;
    localparam int ADDR_W        = 3;
    localparam logic REG_THRESHOLD = 1'b0;

    // normaliser datapath widths
    localparam int MAG_W  = 31;
    localparam int ROOT_W = 32;

    // cycles through one normaliser: abs, scale, square, sum, root, divide, clamp
    function automatic int norm_lat(input int f);
        return 4 + ROOT_W + (f + 1) + 1;
    endfunction

    // one result word as it leaves the block
    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] binormal_x;
        logic signed [15:0] binormal_y;
        logic signed [15:0] binormal_z;
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
    } result_t;

endpackage
`default_nettype wire

/* hw/rtl/tfb_if.sv */
// tfb_if: input and output stream interfaces of the frame builder
`default_nettype none
interface tfb_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;

    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface tfb_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] binormal_x;
    logic signed [15:0] binormal_y;
    logic signed [15:0] binormal_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;

    modport source (output valid, normal_x, normal_y, normal_z, binormal_x, binormal_y,
                    binormal_z, tangent_x, tangent_y, tangent_z, origin_x, origin_y,
                    origin_z, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, binormal_x, binormal_y,
                    binormal_z, tangent_x, tangent_y, tangent_z, origin_x, origin_y,
                    origin_z, output ready);
endinterface
`default_nettype wire

/* hw/rtl/tfb_regs.sv */
// tfb_regs: apb register file holding the parallel threshold
`default_nettype none
module tfb_regs
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tfb_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output logic      [tfb_pkg::THR_W-1:0]   threshold
);

    logic [tfb_pkg::THR_W-1:0] thr_reg;
    logic                      hit;

    assign hit    = (paddr[tfb_pkg::ADDR_W-1:2] == tfb_pkg::REG_THRESHOLD);
    assign pready = 1'b1;

    // register write in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= tfb_pkg::THR_W'(tfb_pkg::THR_RESET);
        end
        else if (psel && penable && pwrite && hit)
        begin
            thr_reg <= pwdata[tfb_pkg::THR_W-1:0];
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata = 32'(thr_reg);
        end
    end

    assign threshold = thr_reg;

endmodule
`default_nettype wire

/* hw/rtl/tfb_delay.sv */
// tfb_delay: stallable register delay line for side data of the pipeline
`default_nettype none
module tfb_delay #(
    parameter int W = 1,
    parameter int D = 1
)
(
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] din,
    output logic      [W-1:0] dout
);

    logic [W-1:0] stage_reg [D];

    // shift on every pipeline advance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= din;
            for (int i = 1; i < D; i++)
            begin
                stage_reg[i] <= stage_reg[i-1];
            end
        end
    end

    assign dout = stage_reg[D-1];

endmodule
`default_nettype wire

/* hw/rtl/tfb_norm.sv */
// tfb_norm: pipelined 3-vector normaliser (scale, square root, rounded division)
`default_nettype none
module tfb_norm #(
    parameter int IN_W = 32,
    parameter int F    = tfb_pkg::UNIT_FRAC_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic signed [IN_W-1:0] vin  [3],
    output logic signed      [F+1:0]    vout [3]
);

    localparam int MW   = tfb_pkg::MAG_W;
    localparam int SQW  = 2 * MW;
    localparam int SUMW = 64;
    localparam int RTW  = tfb_pkg::ROOT_W;
    localparam int RMW  = 65;
    localparam int TW   = 66;
    localparam int DW   = F + 32;
    localparam int QW   = F + 1;
    localparam int UW   = F + 2;

    // stage a: sign and magnitude
    logic [IN_W-1:0] mag_a_reg [3];
    logic [2:0]      neg_a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg_a_reg[i] <= vin[i][IN_W-1];
                mag_a_reg[i] <= vin[i][IN_W-1] ? IN_W'(-vin[i]) : IN_W'(vin[i]);
            end
        end
    end

    // stage b: scale down until the largest magnitude fits 31 bits
    logic [IN_W-1:0] mx;
    int              blen;
    int              sh;
    logic [MW-1:0]   m_b_next [3];
    logic [MW-1:0]   m_b_reg  [3];
    logic [2:0]      neg_b_reg;

    always_comb
    begin
        mx = mag_a_reg[0];
        if (mag_a_reg[1] > mx)
        begin
            mx = mag_a_reg[1];
        end
        if (mag_a_reg[2] > mx)
        begin
            mx = mag_a_reg[2];
        end
        blen = 0;
        for (int b = 0; b < IN_W; b++)
        begin
            if (mx[b])
            begin
                blen = b + 1;
            end
        end
        sh = (blen > MW) ? blen - MW : 0;
        for (int i = 0; i < 3; i++)
        begin
            m_b_next[i] = MW'(mag_a_reg[i] >> sh);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_b_reg   <= m_b_next;
            neg_b_reg <= neg_a_reg;
        end
    end

    // stage c: squares
    logic [SQW-1:0] sq_c_reg [3];
    logic [MW-1:0]  m_c_reg  [3];
    logic [2:0]     neg_c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_c_reg[i] <= m_b_reg[i] * m_b_reg[i];
            end
            m_c_reg   <= m_b_reg;
            neg_c_reg <= neg_b_reg;
        end
    end

    // stage d: sum of squares
    logic [SUMW-1:0] sum_d_reg;
    logic [MW-1:0]   m_d_reg [3];
    logic [2:0]      neg_d_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_d_reg <= SUMW'(sq_c_reg[0]) + SUMW'(sq_c_reg[1]) + SUMW'(sq_c_reg[2]);
            m_d_reg   <= m_c_reg;
            neg_d_reg <= neg_c_reg;
        end
    end

    // square root, one result bit per stage
    logic [RMW-1:0] rem_s_reg [RTW];
    logic [RTW-1:0] res_s_reg [RTW];
    logic [MW-1:0]  m_s_reg   [RTW][3];
    logic [2:0]     neg_s_reg [RTW];

    for (genvar s = 0; s < RTW; s++)
    begin : g_sqrt
        localparam int J = RTW - 1 - s;
        logic [RMW-1:0] rem_in;
        logic [RTW-1:0] res_in;
        logic [MW-1:0]  m_in [3];
        logic [2:0]     neg_in;
        logic [TW-1:0]  term;
        logic [RMW-1:0] rem_next;
        logic [RTW-1:0] res_next;

        if (s == 0)
        begin : g_first
            assign rem_in = RMW'(sum_d_reg);
            assign res_in = '0;
            assign m_in   = m_d_reg;
            assign neg_in = neg_d_reg;
        end
        else
        begin : g_rest
            assign rem_in = rem_s_reg[s-1];
            assign res_in = res_s_reg[s-1];
            assign m_in   = m_s_reg[s-1];
            assign neg_in = neg_s_reg[s-1];
        end

        // trial subtract of (2r + b) * b
        always_comb
        begin
            term = (TW'(res_in) << (J + 1)) | (TW'(1) << (2 * J));
            if (TW'(rem_in) >= term)
            begin
                rem_next = RMW'(TW'(rem_in) - term);
                res_next = res_in | (RTW'(1) << J);
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_s_reg[s] <= rem_next;
                res_s_reg[s] <= res_next;
                m_s_reg[s]   <= m_in;
                neg_s_reg[s] <= neg_in;
            end
        end
    end

    // rounded division by the length, one quotient bit per stage, three lanes
    logic [DW-1:0]  rem_d_reg [QW][3];
    logic [QW-1:0]  q_d_reg   [QW][3];
    logic [RTW-1:0] len_d_reg [QW];
    logic [2:0]     neg_d2_reg [QW];

    for (genvar d = 0; d < QW; d++)
    begin : g_div
        localparam int K = F - d;
        logic [DW-1:0]  rem_in [3];
        logic [QW-1:0]  q_in   [3];
        logic [RTW-1:0] len_in;
        logic [2:0]     neg_in;
        logic [DW-1:0]  dv;
        logic [DW-1:0]  rem_next [3];
        logic [QW-1:0]  q_next   [3];

        if (d == 0)
        begin : g_first
            assign len_in = res_s_reg[RTW-1];
            assign neg_in = neg_s_reg[RTW-1];
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_in[i] = (DW'(m_s_reg[RTW-1][i]) << F)
                                 + DW'(res_s_reg[RTW-1] >> 1);
                assign q_in[i]   = '0;
            end
        end
        else
        begin : g_rest
            assign len_in = len_d_reg[d-1];
            assign neg_in = neg_d2_reg[d-1];
            assign rem_in = rem_d_reg[d-1];
            assign q_in   = q_d_reg[d-1];
        end

        // compare against the shifted divisor in each lane
        always_comb
        begin
            dv = DW'(len_in) << K;
            for (int i = 0; i < 3; i++)
            begin
                if (rem_in[i] >= dv)
                begin
                    rem_next[i] = rem_in[i] - dv;
                    q_next[i]   = q_in[i] | (QW'(1) << K);
                end
                else
                begin
                    rem_next[i] = rem_in[i];
                    q_next[i]   = q_in[i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_d_reg[d]  <= rem_next;
                q_d_reg[d]    <= q_next;
                len_d_reg[d]  <= len_in;
                neg_d2_reg[d] <= neg_in;
            end
        end
    end

    // clamp to one, zero for a zero length, restore sign
    localparam logic [QW-1:0] ONE = QW'(1) << F;

    logic signed [UW-1:0] vout_next [3];
    logic signed [UW-1:0] vout_reg  [3];
    logic [QW-1:0]        qc;

    always_comb
    begin
        qc = '0;
        for (int i = 0; i < 3; i++)
        begin
            priority if (len_d_reg[QW-1] == '0)
            begin
                qc = '0;
            end
            else if (q_d_reg[QW-1][i] > ONE)
            begin
                qc = ONE;
            end
            else
            begin
                qc = q_d_reg[QW-1][i];
            end
            vout_next[i] = neg_d2_reg[QW-1][i] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vout_reg <= vout_next;
        end
    end

    assign vout = vout_reg;

endmodule
`default_nettype wire

/* hw/rtl/tangent_frame_builder.sv */
// tangent_frame_builder: top level, frame pipeline with apb threshold and output skid
//
// Takes one word per cycle on in_ch (position and velocity, signed Q16.16) and
// returns one word on out_ch per input word: unit normal, binormal and tangent
// (one = 2^UNIT_FRAC_BITS, saturated to 16 bits) plus the position unchanged.
// The parallel threshold is written over the apb port; the user must write it
// only while the block is idle, as the block itself does not enforce it.
// Each result is written into the output buffer, which drives out_ch.valid.
// Each of the three normalisers holds a 32-stage square root and a
// (UNIT_FRAC_BITS+1)-stage divider; these set the latency.
// Throughput is one word per cycle. The pipeline advances as a whole while the
// two-entry output buffer has room, so one result may wait on out_ch while new
// words are still accepted; when both entries are full in_ch.ready drops and
// everything holds, nothing is lost or repeated.
// Reset clears all valid flags, empties the output buffer and sets the threshold to 1.
`default_nettype none
module tangent_frame_builder #(
    parameter int UNIT_FRAC_BITS = tfb_pkg::UNIT_FRAC_BITS
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tfb_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    tfb_in_if.sink                           in_ch,
    tfb_out_if.source                        out_ch
);

    localparam int F    = UNIT_FRAC_BITS;
    localparam int U    = F + 2;
    localparam int NW   = 2 * U + 1;
    localparam int NL   = tfb_pkg::norm_lat(F);
    localparam int TOT  = 3 * NL + 3;
    localparam logic [U-1:0] ONE = U'(1) << F;

    logic                      en;
    logic [tfb_pkg::THR_W-1:0] threshold;

    tfb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .threshold (threshold)
    );

    assign in_ch.ready = en;

    // valid flags travel with the words
    logic [TOT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOT-2:0], in_ch.valid};
        end
    end

    // position runs alongside the whole pipeline
    logic [95:0] pos_d;

    tfb_delay #(.W(96), .D(TOT)) u_pos_dly (
        .clk  (clk),
        .en   (en),
        .din  ({in_ch.pos_x, in_ch.pos_y, in_ch.pos_z}),
        .dout (pos_d)
    );

    // tangent normaliser
    logic signed [31:0]  vel_v [3];
    logic signed [U-1:0] t_v   [3];

    assign vel_v[0] = in_ch.vel_x;
    assign vel_v[1] = in_ch.vel_y;
    assign vel_v[2] = in_ch.vel_z;

    tfb_norm #(.IN_W(32), .F(F)) u_norm_t (
        .clk  (clk),
        .en   (en),
        .vin  (vel_v),
        .vout (t_v)
    );

    // reference axis choice and reference cross tangent
    logic [U-1:0]        atz;
    logic [U-1:0]        slack;
    logic                use_y;
    logic signed [U-1:0] c_next    [3];
    logic signed [U-1:0] c_sel_reg [3];
    logic signed [U-1:0] t_sel_reg [3];

    always_comb
    begin
        atz   = t_v[2][U-1] ? U'(-t_v[2]) : U'(t_v[2]);
        slack = ONE - atz;
        use_y = (32'(slack) <= 32'(threshold));
        if (use_y)
        begin
            c_next[0] = t_v[2];
            c_next[1] = '0;
            c_next[2] = -t_v[0];
        end
        else
        begin
            c_next[0] = -t_v[1];
            c_next[1] = t_v[0];
            c_next[2] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_sel_reg <= c_next;
            t_sel_reg <= t_v;
        end
    end

    // binormal normaliser
    logic signed [U-1:0] b_v [3];

    tfb_norm #(.IN_W(U), .F(F)) u_norm_b (
        .clk  (clk),
        .en   (en),
        .vin  (c_sel_reg),
        .vout (b_v)
    );

    // tangent aligned with the binormal
    logic [3*U-1:0]      t_mid_bus;
    logic signed [U-1:0] t_mid [3];

    tfb_delay #(.W(3 * U), .D(NL)) u_t_dly_a (
        .clk  (clk),
        .en   (en),
        .din  ({t_sel_reg[0], t_sel_reg[1], t_sel_reg[2]}),
        .dout (t_mid_bus)
    );

    assign t_mid[0] = t_mid_bus[3*U-1:2*U];
    assign t_mid[1] = t_mid_bus[2*U-1:U];
    assign t_mid[2] = t_mid_bus[U-1:0];

    // tangent cross binormal: products, then differences
    logic signed [2*U-1:0] p_reg [6];
    logic signed [NW-1:0]  x_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= t_mid[1] * b_v[2];
            p_reg[1] <= t_mid[2] * b_v[1];
            p_reg[2] <= t_mid[2] * b_v[0];
            p_reg[3] <= t_mid[0] * b_v[2];
            p_reg[4] <= t_mid[0] * b_v[1];
            p_reg[5] <= t_mid[1] * b_v[0];
            x_reg[0] <= NW'(p_reg[0]) - NW'(p_reg[1]);
            x_reg[1] <= NW'(p_reg[2]) - NW'(p_reg[3]);
            x_reg[2] <= NW'(p_reg[4]) - NW'(p_reg[5]);
        end
    end

    // normal normaliser
    logic signed [U-1:0] n_v [3];

    tfb_norm #(.IN_W(NW), .F(F)) u_norm_n (
        .clk  (clk),
        .en   (en),
        .vin  (x_reg),
        .vout (n_v)
    );

    // tangent and binormal aligned with the normal
    logic [3*U-1:0] t_fin_bus;
    logic [3*U-1:0] b_fin_bus;

    tfb_delay #(.W(3 * U), .D(NL + 2)) u_t_dly_b (
        .clk  (clk),
        .en   (en),
        .din  (t_mid_bus),
        .dout (t_fin_bus)
    );

    tfb_delay #(.W(3 * U), .D(NL + 2)) u_b_dly (
        .clk  (clk),
        .en   (en),
        .din  ({b_v[0], b_v[1], b_v[2]}),
        .dout (b_fin_bus)
    );

    // saturate a unit component into 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [U-1:0] v);
        logic signed [32:0] e;
        e = 33'(v);
        if (e > 33'sd32767)
        begin
            return 16'sd32767;
        end
        if (e < -33'sd32768)
        begin
            return -16'sd32768;
        end
        return 16'(e);
    endfunction

    // result word assembly
    tfb_pkg::result_t res_word;

    always_comb
    begin
        res_word.normal_x   = sat16(n_v[0]);
        res_word.normal_y   = sat16(n_v[1]);
        res_word.normal_z   = sat16(n_v[2]);
        res_word.binormal_x = sat16($signed(b_fin_bus[3*U-1:2*U]));
        res_word.binormal_y = sat16($signed(b_fin_bus[2*U-1:U]));
        res_word.binormal_z = sat16($signed(b_fin_bus[U-1:0]));
        res_word.tangent_x  = sat16($signed(t_fin_bus[3*U-1:2*U]));
        res_word.tangent_y  = sat16($signed(t_fin_bus[2*U-1:U]));
        res_word.tangent_z  = sat16($signed(t_fin_bus[U-1:0]));
        res_word.origin_x   = $signed(pos_d[95:64]);
        res_word.origin_y   = $signed(pos_d[63:32]);
        res_word.origin_z   = $signed(pos_d[31:0]);
    end

    // two-entry output buffer decoupling the pipeline from the receiver
    tfb_pkg::result_t obuf_mem [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign en   = (count_reg != 2'd2);
    assign push = en && vld_reg[TOT-1];
    assign pop  = out_ch.valid && out_ch.ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            obuf_mem[wr_ptr_reg] <= res_word;
        end
    end

    always_comb
    begin
        count_next = 2'(count_reg + 2'(push) - 2'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // output word
    assign out_ch.valid      = (count_reg != 2'd0);
    assign out_ch.normal_x   = obuf_mem[rd_ptr_reg].normal_x;
    assign out_ch.normal_y   = obuf_mem[rd_ptr_reg].normal_y;
    assign out_ch.normal_z   = obuf_mem[rd_ptr_reg].normal_z;
    assign out_ch.binormal_x = obuf_mem[rd_ptr_reg].binormal_x;
    assign out_ch.binormal_y = obuf_mem[rd_ptr_reg].binormal_y;
    assign out_ch.binormal_z = obuf_mem[rd_ptr_reg].binormal_z;
    assign out_ch.tangent_x  = obuf_mem[rd_ptr_reg].tangent_x;
    assign out_ch.tangent_y  = obuf_mem[rd_ptr_reg].tangent_y;
    assign out_ch.tangent_z  = obuf_mem[rd_ptr_reg].tangent_z;
    assign out_ch.origin_x   = obuf_mem[rd_ptr_reg].origin_x;
    assign out_ch.origin_y   = obuf_mem[rd_ptr_reg].origin_y;
    assign out_ch.origin_z   = obuf_mem[rd_ptr_reg].origin_z;

endmodule
`default_nettype wire

/* dv/tb_tangent_frame_builder.sv */
// tb_tangent_frame_builder: self-checking stream testbench for the tangent frame builder
`timescale 1ns / 1ps
module tb_tangent_frame_builder;

    typedef longint vec3_t [3];

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [tfb_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    tfb_in_if  in_ch ();
    tfb_out_if out_ch ();

    tangent_frame_builder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // threshold as currently programmed
    logic [tfb_pkg::THR_W-1:0] thr_now = tfb_pkg::THR_W'(tfb_pkg::THR_RESET);
    tfb_pkg::result_t frame_q [$];
    int send_idle = 0;
    int recv_idle = 0;
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int y_ref_hits = 0;
    logic in_taken = 1'b0;

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.pos_z = '0;
        in_ch.vel_x = '0;
        in_ch.vel_y = '0;
        in_ch.vel_z = '0;
        out_ch.ready = 1'b0;
    end

    // integer square root, floor
    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // scale vector to unit length, one = 2^UNIT_FRAC_BITS
    function automatic void unit_vec(input vec3_t v, output vec3_t u);
        longint unsigned m [3];
        longint unsigned mx;
        longint unsigned len;
        longint unsigned q;
        longint unsigned one;
        one = 64'd1 << tfb_pkg::UNIT_FRAC_BITS;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (v[i] < 0) ? 64'd0 - longint'(v[i]) : v[i];
            if (m[i] > mx)
                mx = m[i];
        end
        while (mx >= (64'd1 << 31))
        begin
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        len = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++)
        begin
            q = 0;
            if (len != 0)
            begin
                q = ((m[i] << tfb_pkg::UNIT_FRAC_BITS) + (len >> 1)) / len;
                if (q > one)
                    q = one;
            end
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic logic signed [15:0] sat16(input longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    // expected frame for one input word
    function automatic tfb_pkg::result_t build_frame(input logic signed [31:0] px, py, pz,
                                                     input logic signed [31:0] vx, vy, vz,
                                                     input logic [tfb_pkg::THR_W-1:0] thr,
                                                     output logic used_y);
        vec3_t v, t, c, b, n;
        longint atz;
        tfb_pkg::result_t r;
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        unit_vec(v, t);
        atz = (t[2] < 0) ? -t[2] : t[2];
        used_y = ((longint'(1) << tfb_pkg::UNIT_FRAC_BITS) - atz) <= longint'(thr);
        if (used_y)
        begin
            c[0] = t[2];
            c[1] = 0;
            c[2] = -t[0];
        end
        else
        begin
            c[0] = -t[1];
            c[1] = t[0];
            c[2] = 0;
        end
        unit_vec(c, b);
        c[0] = t[1] * b[2] - t[2] * b[1];
        c[1] = t[2] * b[0] - t[0] * b[2];
        c[2] = t[0] * b[1] - t[1] * b[0];
        unit_vec(c, n);
        r.normal_x = sat16(n[0]);
        r.normal_y = sat16(n[1]);
        r.normal_z = sat16(n[2]);
        r.binormal_x = sat16(b[0]);
        r.binormal_y = sat16(b[1]);
        r.binormal_z = sat16(b[2]);
        r.tangent_x = sat16(t[0]);
        r.tangent_y = sat16(t[1]);
        r.tangent_z = sat16(t[2]);
        r.origin_x = px;
        r.origin_y = py;
        r.origin_z = pz;
        return r;
    endfunction

    // input monitor: predict on every accepted word
    always @(posedge clk)
    begin
        logic hit_y;
        in_taken <= in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            frame_q.push_back(build_frame(in_ch.pos_x, in_ch.pos_y, in_ch.pos_z,
                                          in_ch.vel_x, in_ch.vel_y, in_ch.vel_z,
                                          thr_now, hit_y));
            if (hit_y)
                y_ref_hits++;
            words_in++;
        end
    end

    task automatic check_field(input string nm, input longint e, input longint a);
        if (e != a)
        begin
            $display("%0t: mismatch %s expected %0d actual %0d", $time, nm, e, a);
            errors++;
        end
    endtask

    // output checker against the oldest expected frame
    always @(posedge clk)
    begin
        tfb_pkg::result_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            words_out++;
            if (frame_q.size() == 0)
            begin
                $display("%0t: unexpected word, nothing pending", $time);
                errors++;
            end
            else
            begin
                e = frame_q.pop_front();
                check_field("normal_x", e.normal_x, out_ch.normal_x);
                check_field("normal_y", e.normal_y, out_ch.normal_y);
                check_field("normal_z", e.normal_z, out_ch.normal_z);
                check_field("binormal_x", e.binormal_x, out_ch.binormal_x);
                check_field("binormal_y", e.binormal_y, out_ch.binormal_y);
                check_field("binormal_z", e.binormal_z, out_ch.binormal_z);
                check_field("tangent_x", e.tangent_x, out_ch.tangent_x);
                check_field("tangent_y", e.tangent_y, out_ch.tangent_y);
                check_field("tangent_z", e.tangent_z, out_ch.tangent_z);
                check_field("origin_x", e.origin_x, out_ch.origin_x);
                check_field("origin_y", e.origin_y, out_ch.origin_y);
                check_field("origin_z", e.origin_z, out_ch.origin_z);
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_idle);

    // send one word from the current falling edge, with random idle cycles in front
    task automatic send_word(input logic [31:0] px, py, pz, vx, vy, vz);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.pos_x = px;
        in_ch.pos_y = py;
        in_ch.pos_z = pz;
        in_ch.vel_x = vx;
        in_ch.vel_y = vy;
        in_ch.vel_z = vz;
        @(negedge clk);
        while (!in_taken)
            @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // wait for every pending frame, then let the pipeline drain
    task automatic drain;
        in_ch.valid = 1'b0;
        while (frame_q.size() != 0)
            @(negedge clk);
        repeat (3 * (tfb_pkg::UNIT_FRAC_BITS + 38) + 20)
            @(negedge clk);
    endtask

    // apb write: setup then access
    task automatic write_threshold(input logic [tfb_pkg::THR_W-1:0] thr);
        drain();
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = tfb_pkg::ADDR_W'(tfb_pkg::REG_THRESHOLD) << 2;
        pwdata = 32'(thr);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        thr_now = thr;
    endtask

    function automatic logic [31:0] rand_vel_comp(input int kind);
        case (kind)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 131072)) - 65536);
            2: return 32'($signed($urandom_range(0, 64)) - 32);
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    task automatic test_directed;
        logic [31:0] mn;
        logic [31:0] mx;
        mn = 32'h8000_0000;
        mx = 32'h7fff_ffff;
        // zero velocity gives all-zero vectors
        send_word(mx, mn, 0, 0, 0, 0);
        // single axis extremes
        send_word(mn, mx, mn, mx, 0, 0);
        send_word(1, 2, 3, mn, 0, 0);
        send_word(0, 0, 0, 0, mx, 0);
        send_word(0, 0, 0, 0, mn, 0);
        // along z: reference switches to y
        send_word(0, 0, 0, 0, 0, mx);
        send_word(0, 0, 0, 0, 0, mn);
        send_word(0, 0, 0, 0, 0, 1);
        // near z, just either side of the threshold
        send_word(0, 0, 0, 32'd200, 0, 32'd65536);
        send_word(0, 0, 0, 32'd300, 32'd100, -32'sd65536);
        send_word(0, 0, 0, 32'd1000, 0, 32'd65536);
        send_word(0, 0, 0, 32'd4000, 32'd3000, 32'd65536);
        // all extremes together
        send_word(mn, mn, mn, mn, mn, mn);
        send_word(mx, mx, mx, mx, mx, mx);
        send_word(mx, mn, mx, mn, mx, mn);
        send_word(32'hffff_ffff, 0, 32'hffff_ffff, -32'sd1, 32'd1, -32'sd1);
        send_word(0, 0, 0, 32'd1, 32'd1, 0);
        send_word(0, 0, 0, 32'd65536, 32'd65536, 32'd65536);
    endtask

    task automatic test_random(input int count);
        logic [31:0] vx, vy, vz;
        int kind;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 3);
            vx = rand_vel_comp(kind);
            vy = rand_vel_comp(kind);
            vz = rand_vel_comp(kind);
            // near-parallel to z in a fair share of words
            if ($urandom_range(0, 3) == 0)
            begin
                vx = 32'($signed($urandom_range(0, 8000)) - 4000);
                vy = 32'($signed($urandom_range(0, 8000)) - 4000);
                vz = $urandom_range(0, 1) ? 32'h0010_0000 : 32'hfff0_0000;
            end
            send_word($urandom, $urandom, $urandom, vx, vy, vz);
            // hold off once until the pipeline is empty
            if (i == count / 2)
                while (frame_q.size() != 0)
                    @(negedge clk);
        end
    endtask

    task automatic test_threshold_sweep;
        write_threshold(0);
        test_directed();
        test_random(150);
        write_threshold(1024);
        test_directed();
        test_random(150);
        write_threshold(11'($urandom_range(2, 1023)));
        test_random(150);
        write_threshold(1);
    endtask

    task automatic test_idle_phases;
        send_idle = 32;
        recv_idle = 60;
        test_random(400);
        send_idle = 60;
        recv_idle = 32;
        test_random(400);
        send_idle = 0;
        recv_idle = 0;
        test_random(400);
    endtask

    initial
    begin
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_threshold_sweep();
        test_idle_phases();
        drain();
        $display("covered %0d words in, %0d out, %0d with the y reference axis",
                 words_in, words_out, y_ref_hits);
        $display("threshold swept over 0, 1024, a random value and the reset value");
        if (errors == 0 && frame_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/tfb_pkg.sv
hw/rtl/tfb_if.sv
hw/rtl/tfb_regs.sv
hw/rtl/tfb_delay.sv
hw/rtl/tfb_norm.sv
hw/rtl/tangent_frame_builder.sv
dv/tb_tangent_frame_builder.sv
